/* rtl/core/lcdi_pkg.sv */
`timescale 1ns / 1ps

package lcdi_pkg;

  // opcodes of the init table
  localparam logic [7:0] OP_SEL_LO = 8'd0;
  localparam logic [7:0] OP_CMD    = 8'd1;
  localparam logic [7:0] OP_RUN    = 8'd6;
  localparam logic [7:0] OP_CMD_D1 = 8'd7;
  localparam logic [7:0] OP_CMD_D2 = 8'd8;
  localparam logic [7:0] OP_SEL_HI = 8'd11;
  localparam logic [7:0] OP_DELAY  = 8'd12;

  // result actions
  typedef enum logic [1:0] {
    ACT_SEND  = 2'd0,
    ACT_SELLO = 2'd1,
    ACT_SELHI = 2'd2,
    ACT_DELAY = 2'd3
  } action_t;

  // most results one table byte can cause
  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic [7:0] table_byte;
    logic       end_of_table;
  } item_t;

  typedef struct packed {
    logic [1:0] action;
    logic       is_data;
    logic [7:0] value;
    logic       last_of_run;
  } result_t;

  // results of one table byte, as they travel from parser to emitter
  typedef struct packed {
    logic [1:0]                cnt;
    result_t [MAX_RES-1:0]     res;
  } group_t;

  // parser phases
  typedef enum logic [9:0] {
    PH_IDLE   = 10'b0000000001,
    PH_CMD1   = 10'b0000000010,
    PH_LEN6   = 10'b0000000100,
    PH_DATA6  = 10'b0000001000,
    PH_C7_CMD = 10'b0000010000,
    PH_C7_DAT = 10'b0000100000,
    PH_C8_CMD = 10'b0001000000,
    PH_C8_D1  = 10'b0010000000,
    PH_C8_D2  = 10'b0100000000,
    PH_DELAY  = 10'b1000000000
  } phase_t;

endpackage

/* rtl/core/lcdi_front.sv */
`timescale 1ns / 1ps

module lcdi_front
  import lcdi_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  input  item_t  item,
  output logic   item_stall,
  input  logic   grp_full,
  output logic   grp_push,
  output group_t grp
);

  phase_t     phase, phase_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] held_command, held_command_next;
  logic [7:0] held_first_data, held_first_data_next;
  logic [7:0] left_dec;
  logic       accept;
  logic [7:0] b;

  assign b          = item.table_byte;
  assign item_stall = grp_full;
  assign accept     = item_valid && !grp_full;
  assign left_dec   = bytes_left - 8'd1;

  // decode one byte into its results and the next phase
  always_comb begin
    phase_next           = PH_IDLE;
    bytes_left_next      = bytes_left;
    held_command_next    = held_command;
    held_first_data_next = held_first_data;
    grp                  = '0;
    unique case (phase)
      PH_CMD1: begin
        grp.cnt    = 2'd1;
        grp.res[0] = '{ACT_SEND, 1'b0, b, 1'b0};
      end
      PH_LEN6: begin
        bytes_left_next = b;
        phase_next      = (b != 8'd0) ? PH_DATA6 : PH_IDLE;
      end
      PH_DATA6: begin
        grp.cnt         = 2'd1;
        grp.res[0]      = '{ACT_SEND, 1'b1, b, 1'b0};
        bytes_left_next = left_dec;
        phase_next      = (left_dec != 8'd0) ? PH_DATA6 : PH_IDLE;
      end
      PH_C7_CMD: begin
        held_command_next = b;
        phase_next        = PH_C7_DAT;
      end
      PH_C7_DAT: begin
        grp.cnt    = 2'd2;
        grp.res[0] = '{ACT_SEND, 1'b0, held_command, 1'b0};
        grp.res[1] = '{ACT_SEND, 1'b1, b, 1'b0};
      end
      PH_C8_CMD: begin
        held_command_next = b;
        phase_next        = PH_C8_D1;
      end
      PH_C8_D1: begin
        held_first_data_next = b;
        phase_next           = PH_C8_D2;
      end
      PH_C8_D2: begin
        grp.cnt    = 2'd3;
        grp.res[0] = '{ACT_SEND, 1'b0, held_command, 1'b0};
        grp.res[1] = '{ACT_SEND, 1'b1, held_first_data, 1'b0};
        grp.res[2] = '{ACT_SEND, 1'b1, b, 1'b0};
      end
      PH_DELAY: begin
        grp.cnt    = 2'd1;
        grp.res[0] = '{ACT_DELAY, 1'b0, b, 1'b0};
      end
      default: begin
        // idle, and any phase code that means nothing: read an opcode
        unique case (b)
          OP_SEL_LO: begin
            grp.cnt    = 2'd1;
            grp.res[0] = '{ACT_SELLO, 1'b0, 8'd0, 1'b0};
          end
          OP_SEL_HI: begin
            grp.cnt    = 2'd1;
            grp.res[0] = '{ACT_SELHI, 1'b0, 8'd0, 1'b0};
          end
          OP_CMD:    phase_next = PH_CMD1;
          OP_RUN:    phase_next = PH_LEN6;
          OP_CMD_D1: phase_next = PH_C7_CMD;
          OP_CMD_D2: phase_next = PH_C8_CMD;
          OP_DELAY:  phase_next = PH_DELAY;
          default:   phase_next = PH_IDLE;
        endcase
      end
    endcase

    // flag the final result of this byte
    case (grp.cnt)
      2'd1:    grp.res[0].last_of_run = 1'b1;
      2'd2:    grp.res[1].last_of_run = 1'b1;
      2'd3:    grp.res[2].last_of_run = 1'b1;
      default: ;
    endcase

    // end of table drops any open operation
    if (item.end_of_table) begin
      phase_next      = PH_IDLE;
      bytes_left_next = 8'd0;
    end
  end

  assign grp_push = accept && (grp.cnt != 2'd0);

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bytes_left      <= 8'd0;
      held_command    <= 8'd0;
      held_first_data <= 8'd0;
    end else if (accept) begin
      phase           <= phase_next;
      bytes_left      <= bytes_left_next;
      held_command    <= held_command_next;
      held_first_data <= held_first_data_next;
    end
  end

endmodule

/* rtl/core/lcdi_queue.sv */
`timescale 1ns / 1ps

module lcdi_queue
  import lcdi_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  group_t push_data,
  input  logic   pop,
  output group_t head,
  output logic   empty,
  output logic   full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  group_t          mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign head  = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/lcdi_back.sv */
`timescale 1ns / 1ps

module lcdi_back
  import lcdi_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    grp_empty,
  input  group_t  grp_head,
  output logic    grp_pop,
  output logic    result_valid,
  output result_t result,
  input  logic    result_stall
);

  logic [1:0] idx;
  logic       load;
  logic       take;
  logic       at_end;

  // output register is free when empty or being taken this cycle
  assign load    = !result_valid || !result_stall;
  assign take    = load && !grp_empty;
  assign at_end  = (idx == (grp_head.cnt - 2'd1));
  assign grp_pop = take && at_end;

  // walk through the results of the head group, one beat a cycle while the output is free
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx          <= 2'd0;
    end else if (load) begin
      result_valid <= !grp_empty;
      if (take) begin
        idx <= at_end ? 2'd0 : idx + 2'd1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      result <= grp_head.res[idx];
    end
  end

endmodule

/* rtl/core/lcd_init_opcode_interpreter.sv */
`timescale 1ns / 1ps
// channel   valid          stall          payload
// item      item_valid     item_stall     item   (table_byte, end_of_table)
// result    result_valid   result_stall   result (action, is_data, value, last_of_run)
//
// one table byte is taken every cycle while the group queue has room
// a byte causing n results leaves them one beat per cycle while result_stall is low, so the
// result side sets the rate; bytes with no result put nothing on the emitter
// item_stall is high only while the group queue (QDEPTH entries) is full
// synchronous reset puts the parser back to idle and empties queue and output

module lcd_init_opcode_interpreter
  import lcdi_pkg::*;
#(
  parameter int unsigned QDEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  item_t   item,
  output logic    item_stall,
  output logic    result_valid,
  output result_t result,
  input  logic    result_stall
);

  group_t push_grp, head_grp;
  logic   push, pop, q_empty, q_full;

  // parser
  lcdi_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_stall (item_stall),
    .grp_full   (q_full),
    .grp_push   (push),
    .grp        (push_grp)
  );

  // group queue between parser and emitter
  lcdi_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_grp),
    .pop       (pop),
    .head      (head_grp),
    .empty     (q_empty),
    .full      (q_full)
  );

  // emitter
  lcdi_back u_back (
    .clk          (clk),
    .rst          (rst),
    .grp_empty    (q_empty),
    .grp_head     (head_grp),
    .grp_pop      (pop),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall)
  );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import lcdi_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_TAIL  = 20;
  localparam int PHASE_BYTES = 28;

  typedef logic [7:0] tbyte_q_t[$];

  // expected action stream of the init table parser
  class init_table_scoreboard;
    phase_t     phase;
    logic [7:0] run_left;
    logic [7:0] held_cmd;
    logic [7:0] held_d1;
    result_t    expected_q[$];
    int         errors;
    int         beats;

    function new();
      phase    = PH_IDLE;
      run_left = '0;
      held_cmd = '0;
      held_d1  = '0;
      errors   = 0;
      beats    = 0;
    endfunction

    function result_t word(action_t act, logic dat, logic [7:0] val);
      result_t r;
      r.action      = act;
      r.is_data     = dat;
      r.value       = val;
      r.last_of_run = 1'b0;
      return r;
    endfunction

    function string show(result_t r);
      return $sformatf("action=%0d is_data=%0b value=%02h last=%0b",
                       r.action, r.is_data, r.value, r.last_of_run);
    endfunction

    // advance the parser by one table byte and queue the actions it causes
    function void note_item(item_t it);
      result_t    outs[$];
      phase_t     nxt;
      logic [7:0] b;
      b   = it.table_byte;
      nxt = PH_IDLE;
      case (phase)
        PH_CMD1: outs.push_back(word(ACT_SEND, 1'b0, b));
        PH_LEN6: begin
          run_left = b;
          nxt = (b != 8'd0) ? PH_DATA6 : PH_IDLE;
        end
        PH_DATA6: begin
          outs.push_back(word(ACT_SEND, 1'b1, b));
          run_left = run_left - 8'd1;
          nxt = (run_left != 8'd0) ? PH_DATA6 : PH_IDLE;
        end
        PH_C7_CMD: begin
          held_cmd = b;
          nxt = PH_C7_DAT;
        end
        PH_C7_DAT: begin
          outs.push_back(word(ACT_SEND, 1'b0, held_cmd));
          outs.push_back(word(ACT_SEND, 1'b1, b));
        end
        PH_C8_CMD: begin
          held_cmd = b;
          nxt = PH_C8_D1;
        end
        PH_C8_D1: begin
          held_d1 = b;
          nxt = PH_C8_D2;
        end
        PH_C8_D2: begin
          outs.push_back(word(ACT_SEND, 1'b0, held_cmd));
          outs.push_back(word(ACT_SEND, 1'b1, held_d1));
          outs.push_back(word(ACT_SEND, 1'b1, b));
        end
        PH_DELAY: outs.push_back(word(ACT_DELAY, 1'b0, b));
        default: begin
          // opcode decode
          case (b)
            OP_SEL_LO: outs.push_back(word(ACT_SELLO, 1'b0, 8'd0));
            OP_SEL_HI: outs.push_back(word(ACT_SELHI, 1'b0, 8'd0));
            OP_CMD:    nxt = PH_CMD1;
            OP_RUN:    nxt = PH_LEN6;
            OP_CMD_D1: nxt = PH_C7_CMD;
            OP_CMD_D2: nxt = PH_C8_CMD;
            OP_DELAY:  nxt = PH_DELAY;
            default:   nxt = PH_IDLE;
          endcase
        end
      endcase
      // end of table drops whatever is half parsed
      if (it.end_of_table) begin
        nxt = PH_IDLE;
        run_left = '0;
      end
      phase = nxt;
      if (outs.size() > 0) outs[outs.size()-1].last_of_run = 1'b1;
      foreach (outs[i]) expected_q.push_back(outs[i]);
    endfunction

    // compare one accepted beat with the oldest expected action
    function void check_result(result_t got);
      result_t exp;
      beats++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual %s", $time, show(got));
        return;
      end
      exp = expected_q.pop_front();
      if (got.action !== exp.action || got.is_data !== exp.is_data ||
          got.value !== exp.value || got.last_of_run !== exp.last_of_run) begin
        errors++;
        $display("%0t: beat mismatch, expected %s, actual %s", $time, show(exp), show(got));
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  item_t   item = '0;
  logic    item_stall;
  logic    result_valid;
  result_t result;
  logic    result_stall = 1'b0;

  init_table_scoreboard sb = new();

  // idling controls of the two sides
  bit snd_idle_on = 1'b1;
  bit rcv_idle_on = 1'b1;
  bit hold_req    = 1'b0;

  int sent_bytes;
  int useful_bytes;
  int early_ends;

  lcd_init_opcode_interpreter DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item         (item),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  // result sink: random stalls per beat, plus one long hold on request
  initial begin : result_sink
    int wait_n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        wait_n = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (rcv_idle_on) begin
        wait_n = $urandom_range(0, 4);
      end else begin
        wait_n = 0;
      end
      if (wait_n > 0) begin
        result_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!(result_valid && !result_stall));
    end
  end

  // watchdog on cycles with no beat on either channel
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
    $display("lcd_init_opcode_interpreter verification failed");
    $finish;
  end

  function logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // offer one table byte and wait until it is taken
  task send_byte(input logic [7:0] b, input logic eot);
    int gap;
    gap = snd_idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{table_byte: b, end_of_table: eot};
    do @(posedge clk); while (item_stall);
    sb.note_item(item);
    sent_bytes++;
  endtask

  // send a byte sequence; eot_at >= 0 ends the table there and drops the rest
  task send_seq(input tbyte_q_t seq, input int eot_at);
    int last_i;
    last_i = (eot_at >= 0) ? eot_at : seq.size() - 1;
    for (int i = 0; i <= last_i; i++) send_byte(seq[i], eot_at == i);
  endtask

  // drop valid and wait until every expected action has come out
  task drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // one random operation, mostly well formed, sometimes cut short
  task random_op(input int max_run);
    tbyte_q_t seq;
    int       kind;
    int       n;
    int       eot_at;
    int       pick;
    kind = $urandom_range(0, 9);
    case (kind)
      0: seq = {OP_SEL_LO};
      1: seq = {OP_SEL_HI};
      2: seq = {OP_CMD, rand_byte()};
      3: begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(7, max_run) : $urandom_range(0, 6);
        seq = {OP_RUN, 8'(n)};
        repeat (n) seq.push_back(rand_byte());
      end
      4: seq = {OP_CMD_D1, rand_byte(), rand_byte()};
      5: seq = {OP_CMD_D2, rand_byte(), rand_byte(), rand_byte()};
      6: seq = {OP_DELAY, rand_byte()};
      default: seq = {rand_byte()};
    endcase
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      eot_at = $urandom_range(0, seq.size() - 1);
      if (eot_at < seq.size() - 1) early_ends++;
    end else if (pick == 1) begin
      eot_at = seq.size() - 1;
    end else begin
      eot_at = -1;
    end
    send_seq(seq, eot_at);
    if (kind <= 6) useful_bytes += (eot_at >= 0) ? eot_at + 1 : seq.size();
  endtask

  initial begin : stimulus
    tbyte_q_t seq;
    int       target;
    sent_bytes = 0;
    useful_bytes = 0;
    early_ends = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: each opcode, field extremes, end flag cases
    seq = {OP_SEL_LO};                        send_seq(seq, -1);
    seq = {OP_SEL_HI};                        send_seq(seq, -1);
    seq = {OP_CMD, 8'hFF};                    send_seq(seq, -1);
    seq = {OP_RUN, 8'd1, 8'hAA};              send_seq(seq, -1);
    seq = {OP_RUN, 8'd0};                     send_seq(seq, -1);
    seq = {OP_CMD_D1, 8'h00, 8'hFF};          send_seq(seq, -1);
    seq = {OP_CMD_D2, 8'hFF, 8'h80, 8'h7F};   send_seq(seq, -1);
    seq = {OP_DELAY, 8'hFF};                  send_seq(seq, -1);
    seq = {8'hFF};                            send_seq(seq, -1);
    // two-data command cut after its first data byte
    seq = {OP_CMD_D2, 8'h11, 8'h22};          send_seq(seq, 2);
    // run cut short, the data already sent stays
    seq = {OP_RUN, 8'd3, 8'h01};              send_seq(seq, 2);
    // end flag on opcodes: select still acts, delay is dropped
    seq = {OP_SEL_LO};                        send_seq(seq, 0);
    seq = {OP_DELAY};                         send_seq(seq, 0);
    early_ends += 3;
    drain();

    // random phase with both sides idling
    target = useful_bytes + PHASE_BYTES;
    while (useful_bytes < target) random_op(20);
    drain();

    // back to back, no idling on either side
    snd_idle_on = 1'b0;
    rcv_idle_on = 1'b0;
    target = useful_bytes + PHASE_BYTES;
    while (useful_bytes < target) random_op(20);
    drain();

    // long receiver hold while the sender keeps offering bytes
    hold_req = 1'b1;
    target = useful_bytes + PHASE_BYTES;
    while (useful_bytes < target) random_op(20);
    drain();

    // receiver idling, sender flat out for one long run, then both sides idling
    rcv_idle_on = 1'b1;
    seq = {OP_RUN, 8'($urandom_range(40, 60))};
    repeat (int'(seq[1])) seq.push_back(rand_byte());
    send_seq(seq, -1);
    snd_idle_on = 1'b1;
    target = useful_bytes + PHASE_BYTES;
    while (useful_bytes < target) random_op(20);
    drain();
    repeat (DRAIN_TAIL) @(posedge clk);

    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected beats never came", $time, sb.pending());
    end
    $display("covered %0d table bytes with %0d action beats checked, %0d tables ended early",
             sent_bytes, sb.beats, early_ends);
    $display("every opcode, zero and long runs, unknown bytes, stalls and a long output hold");
    if (sb.errors == 0) begin
      $display("lcd_init_opcode_interpreter verification clean");
    end else begin
      $display("lcd_init_opcode_interpreter verification failed");
    end
    $finish;
  end

endmodule
